FILE: hdl/sef_pkg.sv
// ----------------------------------------------------------------------------
// sef_pkg
// shared types and constants for the sobel edge magnitude filter
// ----------------------------------------------------------------------------
package sef_pkg;

    // configuration registers
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1280;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd720;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // line geometry
    localparam int DEF_MAX_LINE_WIDTH = 2048;
    localparam int ROW_W              = 11;
    localparam logic [CFG_W-1:0] MAX_LINES = 12'd2048;

    // pixel and luminance
    localparam int COLOR_W = 8;
    localparam int LUM_W   = 12;
    localparam logic [LUM_W-1:0] LUM_R = 12'd5;
    localparam logic [LUM_W-1:0] LUM_G = 12'd9;
    localparam logic [LUM_W-1:0] LUM_B = 12'd2;

    // gradient arithmetic
    localparam int SUM_W    = 14;   // t + 2m + b of one column
    localparam int DIFF_W   = 16;   // signed difference of two column sums
    localparam int ENERGY_W = 29;   // sx^2 + sy^2
    localparam int Q_W      = 18;   // clipped, quantized energy
    localparam logic [Q_W-1:0] ENERGY_LIMIT = 18'd262143;
    localparam logic [Q_W-1:0] QUANT_MASK   = 18'h3ffe0;
    localparam int ROOT_W   = 19;
    localparam int BIT_W    = 17;
    localparam int STEP_W   = 4;
    localparam logic [STEP_W-1:0] ROOT_STEPS_LAST = 4'd8;

    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQX,
        ST_SQY,
        ST_CLIP,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/sobel_edge_magnitude_filter.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_filter
// 3x3 sobel gradient magnitude on a raster rgb stream, two line stores in ram
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: red, green, blue
//  m_*       out  m_tvalid/m_tready  m_tdata: edge_level, m_tuser: border
//  cfg_*     in   cfg_we             cfg_index, cfg_data (image_width/height)
//
//  one pixel at a time: accept, line store read, sobel sums, two squares
//  on one shared multiplier, clip, then a nine-step restoring square root;
//  the input beat is taken while the previous result still waits in the
//  output register; a stalled output holds the finished result in ST_DONE
//  rst_n clears counters, window, state and config; line stores are not
//  cleared; entries not yet written in the frame feed only border outputs
//
module sobel_edge_magnitude_filter #(
    parameter int MAX_LINE_WIDTH = sef_pkg::DEF_MAX_LINE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side: [7:0] red, [15:8] green, [23:16] blue
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [3*sef_pkg::COLOR_W-1:0]  s_tdata,
    // master side: [7:0] edge_level
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sef_pkg::LEVEL_W-1:0]    m_tdata,
    // [0] border
    output logic                           m_tuser,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [sef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sef_pkg::CFG_W-1:0]      cfg_data
);

    import sef_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    // wide enough for the configured width and for col + 1
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_LINE_WIDTH);

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, out-of-range values clamp
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;

    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(MIN_DIM))
            width_eff = CMP_W'(MIN_DIM);
        else if (width_ext > MAX_W)
            width_eff = MAX_W;
        else
            width_eff = width_ext;

        if (image_height_reg < MIN_DIM)
            height_eff = MIN_DIM;
        else if (image_height_reg > MAX_LINES)
            height_eff = MAX_LINES;
        else
            height_eff = image_height_reg;
    end

    // ---------------------------------------------------------------- control
    state_t state_reg, state_next;
    logic   accept;
    logic   out_load;
    logic [STEP_W-1:0] step_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_CLIP;
            ST_CLIP: state_next = ST_ROOT;
            ST_ROOT: if (step_reg == '0) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------- position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CMP_W-1:0] col_inc;
    logic [CFG_W-1:0] row_inc;

    assign col_inc = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc = CFG_W'(row_reg) + CFG_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_inc >= width_eff)
            begin
                col_reg <= '0;
                if (row_inc >= height_eff)
                    row_reg <= '0;
                else
                    row_reg <= row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------ luminance
    logic [COLOR_W-1:0] red, green, blue;
    logic [LUM_W-1:0]   lum_next;
    logic [LUM_W-1:0]   lum_reg;
    logic [COL_W-1:0]   addr_reg;
    logic               border_reg;

    assign red   = s_tdata[COLOR_W-1:0];
    assign green = s_tdata[2*COLOR_W-1:COLOR_W];
    assign blue  = s_tdata[3*COLOR_W-1:2*COLOR_W];
    assign lum_next = LUM_R * LUM_W'(red) + LUM_G * LUM_W'(green) + LUM_B * LUM_W'(blue);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lum_reg    <= lum_next;
            addr_reg   <= col_reg;
            border_reg <= (col_reg < COL_W'(2)) || (row_reg < ROW_W'(2));
        end
    end

    // ------------------------------------------------------------ line stores
    // upper holds row-2, lower holds row-1; read at accept, written back
    // in the following cycle at the same column, so accesses never overlap
    logic [LUM_W-1:0] upper_q, lower_q;
    logic             ls_we;

    assign ls_we = (state_reg == ST_READ);

    sef_ram #(
        .WIDTH (LUM_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (ls_we),
        .waddr (addr_reg),
        .wdata (lower_q),
        .raddr (col_reg),
        .rdata (upper_q)
    );

    sef_ram #(
        .WIDTH (LUM_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (ls_we),
        .waddr (addr_reg),
        .wdata (lum_reg),
        .raddr (col_reg),
        .rdata (lower_q)
    );

    // ------------------------------------------------------ window and sobel
    // a = column col-2, b = column col-1, c = column just read
    logic [LUM_W-1:0] a_t_reg, a_m_reg, a_b_reg;
    logic [LUM_W-1:0] b_t_reg, b_m_reg, b_b_reg;
    logic [SUM_W-1:0] sum_c, sum_a, sum_t, sum_b;
    logic signed [DIFF_W-1:0] sx, sy;
    logic [SUM_W-1:0] abs_x_next, abs_y_next;
    logic [SUM_W-1:0] abs_x_reg, abs_y_reg;

    always_comb
    begin
        sum_c = SUM_W'(upper_q) + {(SUM_W-1)'(lower_q), 1'b0} + SUM_W'(lum_reg);
        sum_a = SUM_W'(a_t_reg) + {(SUM_W-1)'(a_m_reg), 1'b0} + SUM_W'(a_b_reg);
        sum_t = SUM_W'(a_t_reg) + {(SUM_W-1)'(b_t_reg), 1'b0} + SUM_W'(upper_q);
        sum_b = SUM_W'(a_b_reg) + {(SUM_W-1)'(b_b_reg), 1'b0} + SUM_W'(lum_reg);
        sx = $signed(DIFF_W'(sum_c)) - $signed(DIFF_W'(sum_a));
        sy = $signed(DIFF_W'(sum_t)) - $signed(DIFF_W'(sum_b));
        abs_x_next = sx[DIFF_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
        abs_y_next = sy[DIFF_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_t_reg <= '0;
            a_m_reg <= '0;
            a_b_reg <= '0;
            b_t_reg <= '0;
            b_m_reg <= '0;
            b_b_reg <= '0;
        end
        else if (state_reg == ST_READ)
        begin
            a_t_reg <= b_t_reg;
            a_m_reg <= b_m_reg;
            a_b_reg <= b_b_reg;
            b_t_reg <= upper_q;
            b_m_reg <= lower_q;
            b_b_reg <= lum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            abs_x_reg <= abs_x_next;
            abs_y_reg <= abs_y_next;
        end
    end

    // ------------------------------------------------- energy, shared multiplier
    logic [SUM_W-1:0]    mul_in;
    logic [2*SUM_W-1:0]  square;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-9:0] energy_shr;
    logic [Q_W-1:0]      q_next;

    assign mul_in = (state_reg == ST_SQX) ? abs_x_reg : abs_y_reg;
    assign square = (2*SUM_W)'(mul_in) * (2*SUM_W)'(mul_in);
    assign energy_shr = energy_reg[ENERGY_W-1:8];

    always_comb
    begin
        if (energy_shr > (ENERGY_W-8)'(ENERGY_LIMIT))
            q_next = ENERGY_LIMIT & QUANT_MASK;
        else
            q_next = energy_shr[Q_W-1:0] & QUANT_MASK;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SQX)
            energy_reg <= ENERGY_W'(square);
        else if (state_reg == ST_SQY)
            energy_reg <= energy_reg + ENERGY_W'(square);
    end

    // --------------------------------------------------------- square root
    // restoring digit-by-digit root, one pair of bits per cycle
    logic [Q_W-1:0]    rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [BIT_W-1:0]  bit_val;
    logic [ROOT_W:0]   trial;

    assign bit_val = BIT_W'(1) << {step_reg, 1'b0};
    assign trial   = (ROOT_W+1)'(root_reg) + (ROOT_W+1)'(bit_val);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLIP)
        begin
            rem_reg  <= q_next;
            root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            if ((ROOT_W+1)'(rem_reg) >= trial)
            begin
                rem_reg  <= rem_reg - Q_W'(trial);
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_val);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg == ST_CLIP)
            step_reg <= ROOT_STEPS_LAST;
        else if (state_reg == ST_ROOT && step_reg != '0)
            step_reg <= step_reg - STEP_W'(1);
    end

    // ------------------------------------------------------- output register
    logic                m_tvalid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                border_out_reg;
    logic [LEVEL_W-1:0]  level_next;

    assign level_next = LEVEL_MAX - root_reg[LEVEL_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_reg      <= border_reg ? '0 : level_next;
            border_out_reg <= border_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = level_reg;
    assign m_tuser  = border_out_reg;

endmodule

FILE: hdl/sef_ram.sv
// ----------------------------------------------------------------------------
// sef_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module sef_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
